// ===== src/unique_values_with_counts_assert.svh =====
// Assertion macros used by the checker module of this block.
`ifndef UNIQUE_VALUES_WITH_COUNTS_ASSERT_SVH
`define UNIQUE_VALUES_WITH_COUNTS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UVC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/uvc_pkg.sv =====
package uvc_pkg;

   localparam int TABLE_DEPTH    = 32;
   localparam int VALUE_WIDTH    = 32;
   localparam int POSITION_WIDTH = 16;
   localparam int COUNT_WIDTH    = 16;
   localparam int KIND_WIDTH     = 2;
   localparam int SLOT_WIDTH     = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_WIDTH      = $clog2(TABLE_DEPTH);

   localparam logic [COUNT_WIDTH-1:0]    COUNT_MAX    = '1;
   localparam logic [POSITION_WIDTH-1:0] POSITION_MAX = '1;
   localparam logic [SLOT_WIDTH-1:0]     NO_SLOT      = SLOT_WIDTH'(TABLE_DEPTH);

   localparam logic CMD_PUSH   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_SLOT  = 2'd0,
      KIND_ENTRY = 2'd1,
      KIND_TOTAL = 2'd2
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic                  push;
      logic                  load_entry;
      logic                  load_total;
      logic [SLOT_WIDTH-1:0] rd_ptr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                  out_free;
      logic [SLOT_WIDTH-1:0] entries_used;
   } dp_status_type;

endpackage

// ===== src/uvc_controller.sv =====
module uvc_controller
   import uvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type             state_ff, state_in;
   logic [SLOT_WIDTH-1:0] ptr_ff, ptr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ptr_in         = ptr_ff;
      req_stall      = 1'b1;
      cmd.push       = 1'b0;
      cmd.load_entry = 1'b0;
      cmd.load_total = 1'b0;
      cmd.rd_ptr     = ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               if (req_command == CMD_PUSH) begin
                  cmd.push = 1'b1;
               end else begin
                  ptr_in   = '0;
                  state_in = ST_DUMP;
               end
            end
         end
         ST_DUMP: begin
            if (status.out_free) begin
               if (ptr_ff < status.entries_used) begin
                  cmd.load_entry = 1'b1;
                  ptr_in         = ptr_ff + 1'b1;
               end else begin
                  cmd.load_total = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/uvc_datapath.sv =====
module uvc_datapath
   import uvc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [VALUE_WIDTH-1:0]    req_value,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [KIND_WIDTH-1:0]     rsp_kind,
   output logic [SLOT_WIDTH-1:0]     rsp_slot,
   output logic [VALUE_WIDTH-1:0]    rsp_entry_value,
   output logic [COUNT_WIDTH-1:0]    rsp_occurrences,
   output logic [POSITION_WIDTH-1:0] rsp_first_position,
   output logic                      rsp_overflow,
   output logic                      rsp_last_of_run
);

   logic [VALUE_WIDTH-1:0]    values_ff [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0]    counts_ff [TABLE_DEPTH];
   logic [POSITION_WIDTH-1:0] fpos_ff   [TABLE_DEPTH];

   logic [SLOT_WIDTH-1:0]     used_ff, used_in;
   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic                      overflow_ff, overflow_in;

   logic                      out_valid_ff, out_valid_in;
   kind_type                  out_kind_ff, out_kind_in;
   logic [SLOT_WIDTH-1:0]     out_slot_ff, out_slot_in;
   logic [VALUE_WIDTH-1:0]    out_value_ff, out_value_in;
   logic [COUNT_WIDTH-1:0]    out_count_ff, out_count_in;
   logic [POSITION_WIDTH-1:0] out_pos_ff, out_pos_in;
   logic                      out_ovf_ff, out_ovf_in;
   logic                      out_last_ff, out_last_in;

   logic [TABLE_DEPTH-1:0]    match;
   logic [IDX_WIDTH-1:0]      hit_idx;
   logic                      found;
   logic                      room;
   logic [COUNT_WIDTH-1:0]    hit_count;
   logic [IDX_WIDTH-1:0]      new_idx;
   logic [IDX_WIDTH-1:0]      rd_idx;

   // Every stored value is compared with the request at once; stored values are distinct,
   // so at most one entry matches and the slot is the OR of the matching indexes.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match[i] = (SLOT_WIDTH'(i) < used_ff) && (values_ff[i] == req_value);
         if (match[i]) begin
            hit_idx = hit_idx | IDX_WIDTH'(i);
         end
      end
   end

   assign found     = |match;
   assign room      = used_ff < NO_SLOT;
   assign new_idx   = used_ff[IDX_WIDTH-1:0];
   assign rd_idx    = cmd.rd_ptr[IDX_WIDTH-1:0];
   assign hit_count = (counts_ff[hit_idx] == COUNT_MAX) ? COUNT_MAX
                                                       : counts_ff[hit_idx] + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         if (found) begin
            counts_ff[hit_idx] <= hit_count;
         end else if (room) begin
            values_ff[new_idx] <= req_value;
            counts_ff[new_idx] <= COUNT_WIDTH'(1);
            fpos_ff[new_idx]   <= position_ff;
         end
      end
   end

   always_comb begin
      used_in     = used_ff;
      position_in = position_ff;
      overflow_in = overflow_ff;
      if (cmd.push) begin
         if (position_ff != POSITION_MAX) begin
            position_in = position_ff + 1'b1;
         end
         if (!found) begin
            if (room) begin
               used_in = used_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
         end
      end else if (cmd.load_total) begin
         used_in     = '0;
         position_in = '0;
         overflow_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_kind_in  = out_kind_ff;
      out_slot_in  = out_slot_ff;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      out_pos_in   = out_pos_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      priority if (cmd.push) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_SLOT;
         out_value_in = req_value;
         out_ovf_in   = overflow_in;
         out_last_in  = 1'b1;
         if (found) begin
            out_slot_in  = SLOT_WIDTH'(hit_idx);
            out_count_in = hit_count;
            out_pos_in   = fpos_ff[hit_idx];
         end else if (room) begin
            out_slot_in  = used_ff;
            out_count_in = COUNT_WIDTH'(1);
            out_pos_in   = position_ff;
         end else begin
            out_slot_in  = NO_SLOT;
            out_count_in = '0;
            out_pos_in   = '0;
         end
      end else if (cmd.load_entry) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_ENTRY;
         out_slot_in  = cmd.rd_ptr;
         out_value_in = values_ff[rd_idx];
         out_count_in = counts_ff[rd_idx];
         out_pos_in   = fpos_ff[rd_idx];
         out_ovf_in   = overflow_ff;
         out_last_in  = 1'b0;
      end else if (cmd.load_total) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_TOTAL;
         out_slot_in  = '0;
         out_value_in = '0;
         out_count_in = COUNT_WIDTH'(used_ff);
         out_pos_in   = '0;
         out_ovf_in   = overflow_ff;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         position_ff  <= '0;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         position_ff  <= position_in;
         overflow_ff  <= overflow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_slot_ff  <= out_slot_in;
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
      out_pos_ff   <= out_pos_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
   end

   assign status.out_free     = !out_valid_ff || !rsp_stall;
   assign status.entries_used = used_ff;

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_slot           = out_slot_ff;
   assign rsp_entry_value    = out_value_ff;
   assign rsp_occurrences    = out_count_ff;
   assign rsp_first_position = out_pos_ff;
   assign rsp_overflow       = out_ovf_ff;
   assign rsp_last_of_run    = out_last_ff;

endmodule

// ===== src/unique_values_with_counts.sv =====
// Push: the result is registered and shows in the cycle after the request is taken;
// one push per cycle while the output is free, set by the parallel table compare.
// Finish: entries_used + 1 results, one per cycle while the output is free, from the
// output register; requests are stalled until the distinct count result has been loaded.
// Reset (synchronous, active high) clears the fill count, the element position, the
// overflow flag and the output valid flag; table contents are not cleared.
module unique_values_with_counts
   import uvc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [VALUE_WIDTH-1:0]    req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [KIND_WIDTH-1:0]     rsp_kind,
   output logic [SLOT_WIDTH-1:0]     rsp_slot,
   output logic [VALUE_WIDTH-1:0]    rsp_entry_value,
   output logic [COUNT_WIDTH-1:0]    rsp_occurrences,
   output logic [POSITION_WIDTH-1:0] rsp_first_position,
   output logic                      rsp_overflow,
   output logic                      rsp_last_of_run
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   uvc_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   uvc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_value          (req_value),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_slot           (rsp_slot),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_first_position (rsp_first_position),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// ===== src/uvc_checker.sv =====
`include "unique_values_with_counts_assert.svh"

module uvc_checker
   import uvc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_command,
   input logic [VALUE_WIDTH-1:0]    req_value,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [KIND_WIDTH-1:0]     rsp_kind,
   input logic [SLOT_WIDTH-1:0]     rsp_slot,
   input logic [VALUE_WIDTH-1:0]    rsp_entry_value,
   input logic [COUNT_WIDTH-1:0]    rsp_occurrences,
   input logic [POSITION_WIDTH-1:0] rsp_first_position,
   input logic                      rsp_overflow,
   input logic                      rsp_last_of_run
);

   logic push_taken;

   assign push_taken = req_valid && !req_stall && (req_command == CMD_PUSH);

   `UVC_ASSERT_NEXT(a_push_answered, clock, reset, push_taken, rsp_valid && rsp_kind == KIND_SLOT && rsp_last_of_run, "A push request did not give its slot result in the next cycle.")
   `UVC_ASSERT_SAME(a_entry_not_last, clock, reset, rsp_valid && rsp_kind == KIND_ENTRY, !rsp_last_of_run && rsp_slot < NO_SLOT, "A table entry result is marked last or has no slot.")
   `UVC_ASSERT_SAME(a_total_bounded, clock, reset, rsp_valid && rsp_kind == KIND_TOTAL, rsp_last_of_run && rsp_occurrences <= COUNT_WIDTH'(TABLE_DEPTH), "The distinct count result exceeds the table depth or is not last.")
   `UVC_ASSERT_SAME(a_no_slot_overflow, clock, reset, rsp_valid && rsp_kind == KIND_SLOT && rsp_slot == NO_SLOT, rsp_overflow && rsp_occurrences == '0, "A push without a slot does not report overflow.")
   `UVC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_entry_value) && $stable(rsp_kind), "A stalled result was dropped or changed.")

endmodule

bind unique_values_with_counts uvc_checker u_checker (.*);
